// ===== rtl/core/lrnu_pkg.sv =====
// ----------------------------------------------------------------------------
// lrnu_pkg
// Shared constants, opcodes and controller/datapath handshake types for the
// LFSR random number unit.
// ----------------------------------------------------------------------------
package lrnu_pkg;

  // widths fixed by the field definitions
  localparam int unsigned LFSR_W   = 32;
  localparam int unsigned SEED_W   = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned BCNT_W   = 6;
  localparam int unsigned RANGE_W  = 32;
  localparam int unsigned RES_W    = 33;

  // feedback taps (bit 0 is the output bit)
  localparam int unsigned TAP_A = 1;
  localparam int unsigned TAP_B = 2;
  localparam int unsigned TAP_C = 22;

  // draw and fraction sizing
  localparam int unsigned MAX_BITS      = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned CNT_W         = $clog2(MAX_BITS + 1);
  localparam int unsigned DCNT_W        = $clog2(FRACTION_BITS + 1);
  localparam int unsigned FRAC_W        = FRACTION_BITS + 1;
  localparam int unsigned DIFF_W        = RANGE_W + 1;
  localparam int unsigned PROD_W        = DIFF_W + FRAC_W + 1;

  // opcodes
  localparam logic [OP_W-1:0] OP_UNSIGNED = 2'd0;
  localparam logic [OP_W-1:0] OP_SIGNED   = 2'd1;
  localparam logic [OP_W-1:0] OP_FRACTION = 2'd2;
  localparam logic [OP_W-1:0] OP_RANGE    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, seed the LFSR if it is zero
    logic draw;      // one LFSR step, shift one bit into the value (first bit: sign, in signed mode)
    logic div_init;  // set up the fraction divide
    logic div_step;  // one restoring divide step
    logic mul;       // range width times fraction
    logic fin;       // write the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic            cnt_zero;
    logic            div_done;
    logic [OP_W-1:0] opcode;
  } sts_t;

endpackage

// ===== rtl/core/lrnu_in_if.sv =====
// ----------------------------------------------------------------------------
// lrnu_in_if
// Request channel: valid/ready with opcode, bit count and range bounds.
// ----------------------------------------------------------------------------
interface lrnu_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [lrnu_pkg::OP_W-1:0]            opcode;
  logic [lrnu_pkg::BCNT_W-1:0]          bit_count;
  logic signed [lrnu_pkg::RANGE_W-1:0]  range_low;
  logic signed [lrnu_pkg::RANGE_W-1:0]  range_high;

  modport source (output valid, opcode, bit_count, range_low, range_high, input ready);
  modport sink   (input valid, opcode, bit_count, range_low, range_high, output ready);
endinterface

// ===== rtl/core/lrnu_out_if.sv =====
// ----------------------------------------------------------------------------
// lrnu_out_if
// Result channel: valid/ready with the 33-bit signed result.
// ----------------------------------------------------------------------------
interface lrnu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lrnu_pkg::RES_W-1:0] random_result;

  modport source (output valid, random_result, input ready);
  modport sink   (input valid, random_result, output ready);
endinterface

// ===== rtl/core/lrnu_datapath.sv =====
// ----------------------------------------------------------------------------
// lrnu_datapath
// LFSR, bit accumulator, serial fraction divider, range multiplier and the
// output payload register.
// ----------------------------------------------------------------------------
module lrnu_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [lrnu_pkg::OP_W-1:0]           in_opcode,
  input  logic [lrnu_pkg::BCNT_W-1:0]         in_bit_count,
  input  logic signed [lrnu_pkg::RANGE_W-1:0] in_range_low,
  input  logic signed [lrnu_pkg::RANGE_W-1:0] in_range_high,
  input  logic                                cfg_we,
  input  logic [lrnu_pkg::SEED_W-1:0]         cfg_data,
  input  lrnu_pkg::cmd_t                      cmd,
  output lrnu_pkg::sts_t                      sts,
  output logic signed [lrnu_pkg::RES_W-1:0]   result
);

  logic [lrnu_pkg::SEED_W-1:0]          seed_r;
  logic [lrnu_pkg::LFSR_W-1:0]          lfsr_r, lfsr_nxt;
  logic [lrnu_pkg::OP_W-1:0]            op_r;
  logic [lrnu_pkg::CNT_W-1:0]           n_r, n_nxt;
  logic [lrnu_pkg::CNT_W-1:0]           cnt_r;
  logic                                 first_r;
  logic                                 sign_r;
  logic [lrnu_pkg::MAX_BITS-1:0]        acc_r;
  logic signed [lrnu_pkg::DIFF_W-1:0]   lo_r;
  logic signed [lrnu_pkg::DIFF_W-1:0]   diff_r;
  logic [lrnu_pkg::MAX_BITS-1:0]        rem_r;
  logic [lrnu_pkg::FRACTION_BITS-1:0]   quo_r;
  logic [lrnu_pkg::DCNT_W-1:0]          dcnt_r;
  logic signed [lrnu_pkg::PROD_W-1:0]   prod_r;
  logic signed [lrnu_pkg::RES_W-1:0]    result_r, result_nxt;

  logic                                 fb;
  logic [lrnu_pkg::MAX_BITS-1:0]        den;
  logic [lrnu_pkg::MAX_BITS:0]          rem_sh;
  logic                                 rem_ge;
  logic [lrnu_pkg::FRAC_W-1:0]          frac;
  logic [lrnu_pkg::RES_W-1:0]           mag;

  // clamp the request count: 0..MAX in most modes, 2..MAX in signed mode
  always_comb begin
    if (in_bit_count > lrnu_pkg::BCNT_W'(lrnu_pkg::MAX_BITS)) begin
      n_nxt = lrnu_pkg::CNT_W'(lrnu_pkg::MAX_BITS);
    end else begin
      n_nxt = lrnu_pkg::CNT_W'(in_bit_count);
    end
    if (in_opcode == lrnu_pkg::OP_SIGNED && n_nxt < lrnu_pkg::CNT_W'(2)) begin
      n_nxt = lrnu_pkg::CNT_W'(2);
    end
  end

  assign fb = lfsr_r[0] ^ lfsr_r[lrnu_pkg::TAP_A] ^ lfsr_r[lrnu_pkg::TAP_B]
            ^ lfsr_r[lrnu_pkg::TAP_C];

  always_comb begin
    lfsr_nxt = lfsr_r;
    if (cmd.load && lfsr_r == '0) begin
      lfsr_nxt = seed_r;
    end else if (cmd.draw) begin
      lfsr_nxt = {fb, lfsr_r[lrnu_pkg::LFSR_W-1:1]};
    end
  end

  // divisor 2^n - 1; zero when n is zero
  assign den    = {lrnu_pkg::MAX_BITS{1'b1}} >> (lrnu_pkg::CNT_W'(lrnu_pkg::MAX_BITS) - n_r);
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den};

  // r == 2^n-1 is exactly one; the divider result is only used for r below that
  always_comb begin
    if (n_r == '0) begin
      frac = '0;
    end else if (acc_r == den) begin
      frac = lrnu_pkg::FRAC_W'(1) << lrnu_pkg::FRACTION_BITS;
    end else begin
      frac = {1'b0, quo_r};
    end
  end

  assign mag = lrnu_pkg::RES_W'(acc_r);

  always_comb begin
    case (op_r)
      lrnu_pkg::OP_UNSIGNED: result_nxt = mag;
      lrnu_pkg::OP_SIGNED:   result_nxt = sign_r ? -mag : mag;
      lrnu_pkg::OP_FRACTION: result_nxt = lrnu_pkg::RES_W'(frac);
      lrnu_pkg::OP_RANGE:    result_nxt = lo_r
                                        + prod_r[lrnu_pkg::FRACTION_BITS +: lrnu_pkg::RES_W];
      default:               result_nxt = mag;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= lrnu_pkg::SEED_W'(1);
      lfsr_r <= '0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_data;
      end
      lfsr_r <= lfsr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      n_r     <= n_nxt;
      cnt_r   <= n_nxt;
      first_r <= 1'b1;
      sign_r  <= 1'b0;
      acc_r   <= '0;
      lo_r    <= lrnu_pkg::DIFF_W'(in_range_low);
      diff_r  <= lrnu_pkg::DIFF_W'(in_range_high) - lrnu_pkg::DIFF_W'(in_range_low);
    end
    if (cmd.draw) begin
      cnt_r <= cnt_r - lrnu_pkg::CNT_W'(1);
      if (op_r == lrnu_pkg::OP_SIGNED && first_r) begin
        sign_r  <= lfsr_r[0];
        first_r <= 1'b0;
      end else begin
        acc_r <= {acc_r[lrnu_pkg::MAX_BITS-2:0], lfsr_r[0]};
      end
    end
    if (cmd.div_init) begin
      rem_r  <= acc_r;
      quo_r  <= '0;
      dcnt_r <= lrnu_pkg::DCNT_W'(lrnu_pkg::FRACTION_BITS);
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r - lrnu_pkg::DCNT_W'(1);
      if (rem_ge) begin
        rem_r <= lrnu_pkg::MAX_BITS'(rem_sh - {1'b0, den});
      end else begin
        rem_r <= rem_sh[lrnu_pkg::MAX_BITS-1:0];
      end
      quo_r <= {quo_r[lrnu_pkg::FRACTION_BITS-2:0], rem_ge};
    end
    if (cmd.mul) begin
      // both factors sign-extended to the full product width
      prod_r <= lrnu_pkg::PROD_W'(diff_r) * lrnu_pkg::PROD_W'($signed({1'b0, frac}));
    end
    if (cmd.fin) begin
      result_r <= result_nxt;
    end
  end

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.div_done = (dcnt_r == '0);
  assign sts.opcode   = op_r;
  assign result       = result_r;

endmodule

// ===== rtl/core/lrnu_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrnu_ctrl
// Request sequencer: accept, draw bits, divide, multiply, write result.
// Owns the handshakes and the output valid flag.
// ----------------------------------------------------------------------------
module lrnu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output lrnu_pkg::cmd_t cmd,
  input  lrnu_pkg::sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DRAW = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        if (!sts.cnt_zero) begin
          cmd.draw = 1'b1;
        end else if (sts.opcode == lrnu_pkg::OP_FRACTION
                  || sts.opcode == lrnu_pkg::OP_RANGE) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (!sts.div_done) begin
          cmd.div_step = 1'b1;
        end else if (sts.opcode == lrnu_pkg::OP_RANGE) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // an accepted beat always starts the draw phase
  a_accept_to_draw: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DRAW)
    else $error("accepted request did not enter draw phase");

  // never more than one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

  // result register is only overwritten when its beat is gone or leaving
  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // a new result only appears out of the finish state
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("out valid raised outside finish state");

  // no divide step once the step counter ran out
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> state_r == S_DIV && !sts.div_done)
    else $error("divide stepped past its length");

endmodule

// ===== rtl/core/lfsr_random_number_unit.sv =====
// ----------------------------------------------------------------------------
// lfsr_random_number_unit
// 32-bit Fibonacci LFSR random number unit: unsigned, sign-magnitude,
// Q1.16 fraction and Q16.16 ranged results, one bit drawn per cycle.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+------------------------------------------
//  in_ch     | in  | valid/ready      | opcode[1:0] bit_count[5:0]
//            |     |                  | range_low[31:0] range_high[31:0] (signed)
//  out_ch    | out | valid/ready      | random_result[32:0] (signed)
//  cfg_*     | in  | cfg_we, no ready | cfg_data[31:0] -> seed value
//
//  Sequence, n = clamped bit count: unsigned/signed draw n bits, then finish;
//  fraction adds the divide, range the divide and the multiply. The next beat
//  can be taken in the cycle after the result is written. The serial LFSR step
//  (one bit per cycle) and the 16-step restoring divider set the request time.
//  One request is in flight at a time; in_ch.ready is high while idle, also
//  while a finished beat still sits in the output register.
//  Reset: seed value 1, shift register 0 (seeded at the first request).
//  A stalled output holds the sequencer in its finish state, nothing is lost.
//
module lfsr_random_number_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  lrnu_in_if.sink                     in_ch,
  lrnu_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [lrnu_pkg::SEED_W-1:0] cfg_data
);

  lrnu_pkg::cmd_t cmd;
  lrnu_pkg::sts_t sts;

  // sequencer: handshakes and command issue
  lrnu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: LFSR, accumulator, divider, multiplier, result register
  lrnu_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_opcode     (in_ch.opcode),
    .in_bit_count  (in_ch.bit_count),
    .in_range_low  (in_ch.range_low),
    .in_range_high (in_ch.range_high),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .result        (out_ch.random_result)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LFSR random number unit. A shadow copy of the
// shift register and seed predicts every result beat. Requests are directed
// first (count extremes, all opcodes, zero seed, reversed and degenerate
// ranges), then random. Both channels idle in random bursts, with one long
// output stall and several drain pauses on the request side.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned TAIL_CYCLES = 60;

  typedef struct {
    logic [lrnu_pkg::OP_W-1:0]           opcode;
    logic [lrnu_pkg::BCNT_W-1:0]         bit_count;
    logic signed [lrnu_pkg::RANGE_W-1:0] range_low;
    logic signed [lrnu_pkg::RANGE_W-1:0] range_high;
    bit                                  wait_drain;  // hold off until all results are back
  } draw_req_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lrnu_pkg::SEED_W-1:0] cfg_data;

  lrnu_in_if  in_ch ();
  lrnu_out_if out_ch ();

  lfsr_random_number_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_we (cfg_we),
    .cfg_data (cfg_data)
  );

  // Shadow state of the unit
  logic [lrnu_pkg::LFSR_W-1:0] lfsr_shadow;
  logic [lrnu_pkg::SEED_W-1:0] seed_shadow;

  draw_req_t                  pending_reqs[$];    // requests not yet offered
  logic [lrnu_pkg::RES_W-1:0] want_results[$];    // predicted results, oldest first

  int unsigned cycles;
  int unsigned errors;
  bit in_busy;        // a request beat is being offered
  bit in_taken;       // set at the edge that accepted it
  bit quiet;          // no idling on either side
  bit idle_on;        // idling bursts allowed in this stretch
  bit long_hold_req;  // ask the receiver for one long stall
  int unsigned gap_left;
  int unsigned hold_left;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // n LFSR steps; the first bit out lands in the MSB of the n-bit value.
  function automatic logic [31:0] shift_out_bits(int unsigned n);
    logic [31:0] v;
    v = '0;
    for (int i = n; i > 0; i--) begin
      v[i-1] = lfsr_shadow[0];
      lfsr_shadow = {lfsr_shadow[0] ^ lfsr_shadow[lrnu_pkg::TAP_A]
                     ^ lfsr_shadow[lrnu_pkg::TAP_B] ^ lfsr_shadow[lrnu_pkg::TAP_C],
                     lfsr_shadow[lrnu_pkg::LFSR_W-1:1]};
    end
    return v;
  endfunction

  // r / (2^n - 1) in Q1.16; an all-ones draw gives exactly 1.0
  function automatic longint unsigned unit_fraction(int unsigned n);
    longint unsigned r;
    longint unsigned maxv;
    if (n == 0)
      return 0;
    r = 64'(shift_out_bits(n));
    maxv = (64'd1 << n) - 64'd1;
    return (r << lrnu_pkg::FRACTION_BITS) / maxv;
  endfunction

  function automatic logic [lrnu_pkg::RES_W-1:0] predict_random(draw_req_t r);
    int unsigned n;
    longint res;
    longint lo;
    longint hi;
    longint prod;
    longint unsigned mag;
    logic sgn;
    // zero register is reseeded at the start of each request
    if (lfsr_shadow == '0)
      lfsr_shadow = seed_shadow;
    n = (r.bit_count > lrnu_pkg::MAX_BITS) ? lrnu_pkg::MAX_BITS : 32'(r.bit_count);
    case (r.opcode)
      lrnu_pkg::OP_UNSIGNED: res = 64'(shift_out_bits(n));
      lrnu_pkg::OP_SIGNED: begin
        if (n < 2)
          n = 2;
        mag = 64'(shift_out_bits(1));
        sgn = mag[0];
        mag = 64'(shift_out_bits(n - 1));
        res = sgn ? -longint'(mag) : longint'(mag);
      end
      lrnu_pkg::OP_FRACTION: res = longint'(unit_fraction(n));
      default: begin
        lo = 64'(r.range_low);
        hi = 64'(r.range_high);
        prod = (hi - lo) * longint'(unit_fraction(n));
        res = lo + (prod >>> lrnu_pkg::FRACTION_BITS);  // floor, also for negative spans
      end
    endcase
    return res[lrnu_pkg::RES_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic signed [lrnu_pkg::RANGE_W-1:0] pick_bound();
    logic signed [lrnu_pkg::RANGE_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2: v[31:20] = {12{v[19]}};  // within +-8.0
      3: v = '0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic draw_req_t random_req();
    draw_req_t r;
    r.opcode = lrnu_pkg::OP_W'($urandom_range(0, 3));
    r.bit_count = lrnu_pkg::BCNT_W'($urandom_range(0, 63));
    r.range_low = pick_bound();
    r.range_high = pick_bound();
    r.wait_drain = 1'b0;
    return r;
  endfunction

  task automatic queue_req(logic [lrnu_pkg::OP_W-1:0] op, int unsigned cnt,
                           logic signed [lrnu_pkg::RANGE_W-1:0] lo = 0,
                           logic signed [lrnu_pkg::RANGE_W-1:0] hi = 32'sh0001_0000);
    draw_req_t r;
    r.opcode = op;
    r.bit_count = lrnu_pkg::BCNT_W'(cnt);
    r.range_low = lo;
    r.range_high = hi;
    r.wait_drain = 1'b0;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_random(int unsigned count, int unsigned drain_at);
    draw_req_t r;
    for (int i = 0; i < count; i++) begin
      r = random_req();
      r.wait_drain = (i == drain_at);
      pending_reqs.push_back(r);
    end
  endtask

  // block is idle once nothing is offered and every result is back
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_busy || want_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_seed(logic [lrnu_pkg::SEED_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    seed_shadow = v;
  endtask

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    // toggle between stretches with and without idling
    if ($urandom_range(0, 199) == 0)
      idle_on = ~idle_on;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: changes at the falling edge
  // --------------------------------------------------------------------------

  always @(negedge clk) begin : drv
    logic nv;
    draw_req_t nx;
    if (in_taken) begin
      in_taken = 1'b0;
      in_busy = 1'b0;
    end
    nv = in_busy;
    if (!in_busy && rst_n) begin
      if (gap_left > 0)
        gap_left--;
      else if (!quiet && idle_on && $urandom_range(0, 5) == 0)
        gap_left = $urandom_range(1, 9) - 1;
      else if (pending_reqs.size() != 0
               && !(pending_reqs[0].wait_drain && want_results.size() != 0)) begin
        nx = pending_reqs.pop_front();
        in_ch.opcode <= nx.opcode;
        in_ch.bit_count <= nx.bit_count;
        in_ch.range_low <= nx.range_low;
        in_ch.range_high <= nx.range_high;
        nv = 1'b1;
        in_busy = 1'b1;
      end
    end
    in_ch.valid <= nv;
  end

  // --------------------------------------------------------------------------
  // Result receiver: ready bursts and the one long stall
  // --------------------------------------------------------------------------

  always @(negedge clk) begin : rcv
    logic rdy;
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    rdy = 1'b1;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!quiet && idle_on && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(1, 9) - 1;
      rdy = 1'b0;
    end
    out_ch.ready <= rdy;
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : mon
    draw_req_t acc;
    logic [lrnu_pkg::RES_W-1:0] want;
    if (rst_n) begin
      // accepted request beat -> predicted result
      if (in_ch.valid && in_ch.ready) begin
        acc.opcode = in_ch.opcode;
        acc.bit_count = in_ch.bit_count;
        acc.range_low = in_ch.range_low;
        acc.range_high = in_ch.range_high;
        acc.wait_drain = 1'b0;
        want_results.push_back(predict_random(acc));
        in_taken = 1'b1;
      end
      // accepted result beat -> compare with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (want_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("tb: unexpected result beat %h at cycle %0d",
                     out_ch.random_result, cycles);
        end else begin
          want = want_results.pop_front();
          if (out_ch.random_result !== want) begin
            errors++;
            if (errors <= 10)
              $display("tb: random_result mismatch at cycle %0d: want %h got %h",
                       cycles, want, out_ch.random_result);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = lrnu_pkg::OP_UNSIGNED;
    in_ch.bit_count = '0;
    in_ch.range_low = '0;
    in_ch.range_high = '0;
    out_ch.ready = 1'b0;
    lfsr_shadow = '0;
    seed_shadow = 32'd1;  // reset value
    cycles = 0;
    errors = 0;
    in_busy = 1'b0;
    in_taken = 1'b0;
    quiet = 1'b0;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    gap_left = 0;
    hold_left = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Zero seed before the first request: register stays zero, all bits 0
    write_seed(32'd0);
    queue_req(lrnu_pkg::OP_UNSIGNED, 32);
    queue_req(lrnu_pkg::OP_SIGNED, 63);
    queue_req(lrnu_pkg::OP_FRACTION, 32);
    queue_req(lrnu_pkg::OP_FRACTION, 5);
    queue_req(lrnu_pkg::OP_RANGE, 32, 32'sh8000_0000, 32'sh7fff_ffff);
    queue_req(lrnu_pkg::OP_RANGE, 16, 32'sh0003_0000, -32'sh0002_0000);
    wait_idle();

    // Register still zero, so the next request picks up the all-ones seed
    write_seed(32'hffff_ffff);
    queue_req(lrnu_pkg::OP_UNSIGNED, 0);
    queue_req(lrnu_pkg::OP_UNSIGNED, 1);
    queue_req(lrnu_pkg::OP_UNSIGNED, 32);
    queue_req(lrnu_pkg::OP_UNSIGNED, 33);   // clamped
    queue_req(lrnu_pkg::OP_UNSIGNED, 63);
    queue_req(lrnu_pkg::OP_SIGNED, 0);      // raised to sign + one bit
    queue_req(lrnu_pkg::OP_SIGNED, 1);
    queue_req(lrnu_pkg::OP_SIGNED, 2);
    queue_req(lrnu_pkg::OP_SIGNED, 2);      // chances for negative zero
    queue_req(lrnu_pkg::OP_SIGNED, 2);
    queue_req(lrnu_pkg::OP_SIGNED, 32);
    queue_req(lrnu_pkg::OP_SIGNED, 63);
    queue_req(lrnu_pkg::OP_FRACTION, 0);
    queue_req(lrnu_pkg::OP_FRACTION, 1);    // all-ones draw gives 1.0
    queue_req(lrnu_pkg::OP_FRACTION, 16);
    queue_req(lrnu_pkg::OP_FRACTION, 63);
    queue_req(lrnu_pkg::OP_RANGE, 0, 32'sh0005_0000, 32'sh0009_0000);
    queue_req(lrnu_pkg::OP_RANGE, 32, 32'sh8000_0000, 32'sh7fff_ffff);
    queue_req(lrnu_pkg::OP_RANGE, 32, 32'sh7fff_ffff, 32'sh8000_0000);  // reversed
    queue_req(lrnu_pkg::OP_RANGE, 24, -32'sh0001_8000, -32'sh0001_8000);  // empty span
    queue_req(lrnu_pkg::OP_RANGE, 63, 32'sh0000_0001, -32'sh0000_0001);
    wait_idle();

    // Random run with a long output stall and a drain pause midway.
    // The seed only takes effect on a zero register, which never recurs.
    write_seed($urandom | 32'd1);
    queue_random(500, 250);
    while (pending_reqs.size() > 450)
      @(negedge clk);
    long_hold_req = 1'b1;
    wait_idle();

    write_seed(32'd1);
    queue_random(500, 200);
    wait_idle();

    // last stretch runs at full rate on both sides
    quiet = 1'b1;
    queue_random(250, 250);
    wait_idle();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (want_results.size() != 0)
      errors++;
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
